### hw/rtl/irlin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlin_pkg
// shared constants and the voltage/distance breakpoint tables of the
// ir ranger linearizer
// ----------------------------------------------------------------------------
package irlin_pkg;

	// distance result width (mm, up to 1500)
	localparam int MmW = 11;
	// width of the volts-per-code scale factor
	localparam int VoltW = 10;
	// volts per adc code in unsigned q2.16 (about 0.01289 V)
	localparam logic [VoltW-1:0] VoltPerCode = 10'd845;
	// smallest voltage gap in q2.16 (about 0.0001 V)
	localparam logic [2:0] GapFloor = 3'd7;
	// width of one stored breakpoint voltage
	localparam int PtW = 18;
	// index width covering the largest supported table
	localparam int TblIdxW = 5;
	// entries in the queue between classifier and arithmetic
	localparam int QueueDepth = 4;

	// breakpoint voltages, descending, q2.16; unused entries read as zero
	function automatic logic [PtW-1:0] volt_pt(input logic [TblIdxW-1:0] idx);
		logic [PtW-1:0] r;
		unique case (idx)
			5'd0: r = 18'd167117;
			5'd1: r = 18'd131072;
			5'd2: r = 18'd98304;
			5'd3: r = 18'd79954;
			5'd4: r = 18'd63570;
			5'd5: r = 18'd55706;
			5'd6: r = 18'd47186;
			5'd7: r = 18'd43909;
			5'd8: r = 18'd41288;
			5'd9: r = 18'd38011;
			5'd10: r = 18'd34079;
			5'd11: r = 18'd32768;
			5'd12: r = 18'd30802;
			5'd13: r = 18'd26214;
			default: r = '0;
		endcase
		return r;
	endfunction

	// breakpoint distances in mm; unused entries read as zero
	function automatic logic [MmW-1:0] mm_pt(input logic [TblIdxW-1:0] idx);
		logic [MmW-1:0] r;
		unique case (idx)
			5'd0: r = 11'd200;
			5'd1: r = 11'd300;
			5'd2: r = 11'd400;
			5'd3: r = 11'd500;
			5'd4: r = 11'd600;
			5'd5: r = 11'd700;
			5'd6: r = 11'd800;
			5'd7: r = 11'd900;
			5'd8: r = 11'd1000;
			5'd9: r = 11'd1100;
			5'd10: r = 11'd1200;
			5'd11: r = 11'd1300;
			5'd12: r = 11'd1400;
			5'd13: r = 11'd1500;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/irlin_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlin_front
// scales each adc code to a voltage and picks its table segment
// ----------------------------------------------------------------------------
module irlin_front import irlin_pkg::*; #(
	parameter int TABLE_POINTS = 14,
	parameter int CHANNELS = 4,
	parameter int ADC_BITS = 8,
	localparam int VW = ADC_BITS + VoltW,
	localparam int IW = $clog2(TABLE_POINTS),
	localparam int EW = VW + IW + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [CHANNELS*ADC_BITS-1:0] in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CHANNELS*EW-1:0]       out_data
);

	logic                   valid_s1;
	logic [CHANNELS*EW-1:0] ent_s1;
	logic [CHANNELS*EW-1:0] ent_d;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic [ADC_BITS-1:0] code;
		logic [VW-1:0]       v;
		logic [IW-1:0]       idx;
		logic                far;

		always_comb begin
			code = in_data[c*ADC_BITS +: ADC_BITS];
			v = VW'(code) * VW'(VoltPerCode);
			// first point below the voltage wins: scan down so lower indexes override
			idx = IW'(1);
			far = 1'b1;
			for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
				if (v > VW'(volt_pt(TblIdxW'(i)))) begin
					idx = IW'(i);
					far = 1'b0;
				end
			end
		end

		assign ent_d[c*EW +: EW] = {far, idx, v};
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_s1 <= ent_d;
		end
	end

endmodule

### hw/rtl/irlin_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlin_fifo
// small flop-based queue decoupling classifier and arithmetic back end
// ----------------------------------------------------------------------------
module irlin_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hw/rtl/irlin_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlin_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module irlin_div import irlin_pkg::*; #(
	parameter int NW = 30,
	parameter int DW = 19
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	output logic [MmW-1:0] quo
);

	// quotient is a blend of table distances, so it always fits in MmW bits
	logic [NW-1:0]  rem_s [MmW];
	logic [DW-1:0]  den_s [MmW];
	logic [MmW-1:0] quo_s [MmW];

	for (genvar i = 0; i < MmW; i++) begin : g_step
		localparam int SH = MmW - 1 - i;
		logic [NW-1:0]  rem_in;
		logic [DW-1:0]  den_in;
		logic [MmW-1:0] quo_in;
		logic [NW-1:0]  trial;
		logic           fits;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = NW'(den_in) << SH;
		assign fits  = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? rem_in - trial : rem_in;
				den_s[i] <= den_in;
				quo_s[i] <= quo_in | (MmW'(fits) << SH);
			end
		end
	end

	assign quo = quo_s[MmW-1];

endmodule

### hw/rtl/irlin_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlin_back
// gap weighting, blend and division per channel, then the output register
// ----------------------------------------------------------------------------
module irlin_back import irlin_pkg::*; #(
	parameter int TABLE_POINTS = 14,
	parameter int CHANNELS = 4,
	parameter int ADC_BITS = 8,
	parameter int OUT_W = 48,
	localparam int VW = ADC_BITS + VoltW,
	localparam int IW = $clog2(TABLE_POINTS),
	localparam int EW = VW + IW + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CHANNELS*EW-1:0] in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_W-1:0]       out_data
);

	localparam int DW = VW + 1;
	localparam int PW = VW + MmW;
	localparam int NW = VW + MmW + 1;
	// gaps, products, numerator, then the divider steps
	localparam int NV = 3 + MmW;

	logic                en;
	logic                vld_s [NV];
	logic [CHANNELS-1:0] far_s [NV];
	logic [MmW-1:0]      quo [CHANNELS];
	logic [CHANNELS-1:0] far_in;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic [OUT_W-1:0]    out_data_d;

	// whole pipe holds while a finished result waits
	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic [EW-1:0]  ent;
		logic [VW-1:0]  v;
		logic [IW-1:0]  idx;
		logic [VW-1:0]  vh;
		logic [VW-1:0]  vl;
		logic [VW-1:0]  dh;
		logic [VW-1:0]  dl;
		logic [VW-1:0]  gl;
		logic [VW-1:0]  gr;
		logic [MmW-1:0] mmh;
		logic [MmW-1:0] mml;
		logic [VW-1:0]  gl_s1;
		logic [VW-1:0]  gr_s1;
		logic [MmW-1:0] mmh_s1;
		logic [MmW-1:0] mml_s1;
		logic [PW-1:0]  phi_s2;
		logic [PW-1:0]  plo_s2;
		logic [DW-1:0]  den_s2;
		logic [NW-1:0]  num_s3;
		logic [DW-1:0]  den_s3;

		always_comb begin
			ent = in_data[c*EW +: EW];
			v   = ent[VW-1:0];
			idx = ent[VW +: IW];
			vh  = VW'(volt_pt(TblIdxW'(idx) - TblIdxW'(1)));
			vl  = VW'(volt_pt(TblIdxW'(idx)));
			mmh = mm_pt(TblIdxW'(idx) - TblIdxW'(1));
			mml = mm_pt(TblIdxW'(idx));
			dh  = (v > vh) ? v - vh : vh - v;
			dl  = (v > vl) ? v - vl : vl - v;
			gl  = (dh < VW'(GapFloor)) ? VW'(GapFloor) : dh;
			gr  = (dl < VW'(GapFloor)) ? VW'(GapFloor) : dl;
		end

		assign far_in[c] = ent[VW+IW];

		always_ff @(posedge clk) begin
			if (en) begin
				gl_s1  <= gl;
				gr_s1  <= gr;
				mmh_s1 <= mmh;
				mml_s1 <= mml;
				// upper distance weighted by the lower gap and vice versa
				phi_s2 <= PW'(gr_s1) * PW'(mmh_s1);
				plo_s2 <= PW'(gl_s1) * PW'(mml_s1);
				den_s2 <= DW'(gl_s1) + DW'(gr_s1);
				// half the divisor added for round half up; far channels divide zero
				num_s3 <= far_s[1][c] ? '0
					: NW'(phi_s2) + NW'(plo_s2) + NW'(den_s2 >> 1);
				den_s3 <= den_s2;
			end
		end

		irlin_div #(
			.NW (NW),
			.DW (DW)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3),
			.den (den_s3),
			.quo (quo[c])
		);
	end

	always_comb begin
		out_data_d = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			out_data_d[c*MmW +: MmW] = quo[c];
		end
		out_data_d[CHANNELS*MmW +: CHANNELS] = far_s[NV-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NV; j++) begin
				vld_s[j] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < NV; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
			out_valid_q <= vld_s[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			far_s[0] <= far_in;
			for (int j = 1; j < NV; j++) begin
				far_s[j] <= far_s[j-1];
			end
			out_data_q <= out_data_d;
		end
	end

endmodule

### hw/rtl/ir_adc_to_distance_linearizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_adc_to_distance_linearizer_core
// converts a set of ir ranger adc codes to distances in mm by
// gap-weighted interpolation over a descending voltage table
// ----------------------------------------------------------------------------
//
// channel   dir  tdata fields (lsb first)                       tuser  tlast
// s_axis    in   code_left_front, code_right_front,             -      -
//                code_left_rear, code_right_rear (ADC_BITS each)
// m_axis    out  mm_left_front, mm_right_front, mm_left_rear,   -      -
//                mm_right_rear (11 bits each), far_flags
//
// one transaction per clock sustained on both sides while m_axis_tready stays high
// from input transaction to result the data passes the classifier register,
//   queue, gap stage, multiply stage, numerator stage, 11 divider steps and the
//   output register; the divider (one quotient bit per step) sets the depth
// m_axis_tready low stalls the whole arithmetic pipe; the 4-entry queue and
//   the classifier register keep taking input until they fill
// arst_n clears all valid and queue state; data registers are not reset
//
module ir_adc_to_distance_linearizer_core import irlin_pkg::*; #(
	parameter int TABLE_POINTS = 14,
	parameter int CHANNELS = 4,
	parameter int ADC_BITS = 8,
	localparam int IN_W = ((CHANNELS * ADC_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((CHANNELS * (MmW + 1) + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// code_left_front, code_right_front, code_left_rear, code_right_rear
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// mm_left_front, mm_right_front, mm_left_rear, mm_right_rear, far_flags
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int VW = ADC_BITS + VoltW;
	localparam int IW = $clog2(TABLE_POINTS);
	// per channel queue entry: voltage, segment index, far flag
	localparam int EW = VW + IW + 1;
	localparam int QW = CHANNELS * EW;

	logic          cls_valid;
	logic          cls_ready;
	logic [QW-1:0] cls_data;
	logic          q_valid;
	logic          q_ready;
	logic [QW-1:0] q_data;

	// front: scale and classify
	irlin_front #(
		.TABLE_POINTS (TABLE_POINTS),
		.CHANNELS     (CHANNELS),
		.ADC_BITS     (ADC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata[CHANNELS*ADC_BITS-1:0]),
		.out_valid (cls_valid),
		.out_ready (cls_ready),
		.out_data  (cls_data)
	);

	// queue lets the classifier run on while the back end is stalled
	irlin_fifo #(
		.WIDTH (QW),
		.DEPTH (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cls_valid),
		.wr_ready (cls_ready),
		.wr_data  (cls_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	// back: interpolation arithmetic and result register
	irlin_back #(
		.TABLE_POINTS (TABLE_POINTS),
		.CHANNELS     (CHANNELS),
		.ADC_BITS     (ADC_BITS),
		.OUT_W        (OUT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_data   (q_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
